### src/bba_pkg.sv
// bitmap allocator package: map geometry, command and status codes, sequencer states
// used by bitmap_block_allocator; depends on nothing
package bba_pkg;

    localparam int MAP_BITS       = 65536;
    localparam int WORD_BITS      = 32;
    localparam int BITS_PER_BYTE  = 8;
    localparam int MAP_WORDS      = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int MAP_BYTES      = MAP_BITS / BITS_PER_BYTE;
    localparam int BYTES_PER_WORD = WORD_BITS / BITS_PER_BYTE;
    localparam int ADDR_W         = $clog2(MAP_WORDS);
    localparam int BIT_W          = $clog2(WORD_BITS);
    localparam int BPW_W          = (BYTES_PER_WORD > 1) ? $clog2(BYTES_PER_WORD) : 1;

    localparam int CMD_W          = 2;
    localparam int INDEX_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int FOUND_W        = 16;
    localparam int COUNT_W        = 17;
    localparam int MAPB_W         = 14;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 17;
    localparam int S_DATA_W       = 40;
    localparam int M_DATA_W       = 24;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = COUNT_W'(65536);
    localparam logic [MAPB_W-1:0]  MAP_BYTES_RESET   = MAPB_W'(8192);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR_ALL = 2'd0,
        CMD_MARK_USED = 2'd1,
        CMD_MARK_FREE = 2'd2,
        CMD_ALLOCATE  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_INDEX = 2'd1,
        STATUS_NO_SPACE = 2'd2
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BLOCK_COUNT = 1'd0,
        REG_MAP_BYTES   = 1'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_MARK_WR,
        ST_SCAN,
        ST_RESP
    } state_t;

endpackage

### src/bitmap_block_allocator.sv
// Item to result: a mark reads and writes its word, then responds; an out-of-range mark
// skips to ST_RESP; clear all writes all words; allocate reads at most ceil(min(map_bytes,
// 8192) / 4) words, one per cycle from the single-read-port memory; one item at a time,
// next accepted in the cycle after the result is loaded, which waits for a free output.
// After reset a clearing pass writes zeros to all MAP_WORDS (2048) words, s_tready low.
// Reset clears the control state and sets block_count 65536, map_bytes 8192.
module bitmap_block_allocator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command [1:0], block_index [33:2], zero fill
    input  logic [bba_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status [1:0], found_index [17:2], zero fill
    output logic [bba_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            cfg_we,
    input  logic [bba_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [bba_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0] mem [0:MAP_WORDS-1];
    logic [WORD_BITS-1:0] rd_data_reg;

    state_t               state_reg, state_next;
    logic [ADDR_W:0]      addr_reg, addr_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [ADDR_W-1:0]    chk_addr_reg, chk_addr_next;
    logic [ADDR_W:0]      lim_words_reg, lim_words_next;
    logic [BPW_W-1:0]     part_reg, part_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    status_t              status_reg, status_next;
    logic [FOUND_W-1:0]   found_reg, found_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [COUNT_W-1:0]   block_count_reg;
    logic [MAPB_W-1:0]    map_bytes_reg;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    cmd_t                 in_cmd;
    logic [INDEX_W-1:0]   in_idx;
    logic                 in_oor;
    logic [MAPB_W-1:0]    bytes_clamped;
    logic [MAPB_W:0]      lim_sum;
    logic                 last_word;
    logic [WORD_BITS-1:0] word_mask, free_bits, low_free;
    logic [BIT_W-1:0]     enc;

    assign in_cmd = cmd_t'(s_tdata[CMD_W-1:0]);
    assign in_idx = s_tdata[CMD_W +: INDEX_W];
    assign in_oor = (in_idx >= INDEX_W'(block_count_reg)) || (in_idx >= INDEX_W'(MAP_BITS));

    assign bytes_clamped = (map_bytes_reg > MAPB_W'(MAP_BYTES)) ? MAPB_W'(MAP_BYTES)
                                                                : map_bytes_reg;
    assign lim_sum = {1'b0, bytes_clamped} + (MAPB_W + 1)'(BYTES_PER_WORD - 1);

    // mask of the bits inside the searched range for the word being checked
    assign last_word = (({1'b0, chk_addr_reg} + (ADDR_W + 1)'(1)) == lim_words_reg);
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            word_mask[b] = !last_word || (part_reg == '0) ||
                           ((b / BITS_PER_BYTE) < int'(part_reg));
        end
    end

    assign free_bits = ~rd_data_reg & word_mask;
    assign low_free  = free_bits & (~free_bits + WORD_BITS'(1));

    always_comb begin
        enc = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (low_free[b]) begin
                enc = enc | BIT_W'(b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_count_reg <= BLOCK_COUNT_RESET;
            map_bytes_reg   <= MAP_BYTES_RESET;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                REG_BLOCK_COUNT: block_count_reg <= cfg_wdata[COUNT_W-1:0];
                REG_MAP_BYTES:   map_bytes_reg   <= cfg_wdata[MAPB_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            addr_reg      <= '0;
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            chk_valid_reg <= chk_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_addr_reg  <= chk_addr_next;
        lim_words_reg <= lim_words_next;
        part_reg      <= part_next;
        cmd_reg       <= cmd_next;
        bit_reg       <= bit_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        m_tdata_reg   <= m_tdata_next;
    end

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        chk_valid_next = 1'b0;
        chk_addr_next  = chk_addr_reg;
        lim_words_next = lim_words_reg;
        part_next      = part_reg;
        cmd_next       = cmd_reg;
        bit_next       = bit_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        s_tready       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg[ADDR_W-1:0];
        mem_wdata      = '0;
        mem_raddr      = in_idx[BIT_W +: ADDR_W];

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                mem_we = 1'b1;
                addr_next = addr_reg + (ADDR_W + 1)'(1);
                if (addr_reg == (ADDR_W + 1)'(MAP_WORDS - 1)) begin
                    addr_next = '0;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_RESP;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_next    = in_cmd;
                    bit_next    = in_idx[BIT_W-1:0];
                    chk_addr_next = in_idx[BIT_W +: ADDR_W];
                    status_next = STATUS_OK;
                    found_next  = '0;
                    case (in_cmd)
                        CMD_CLEAR_ALL: begin
                            addr_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_MARK_USED, CMD_MARK_FREE: begin
                            if (in_oor) begin
                                status_next = STATUS_BAD_INDEX;
                                state_next  = ST_RESP;
                            end else begin
                                state_next = ST_MARK_WR;
                            end
                        end
                        CMD_ALLOCATE: begin
                            lim_words_next = (ADDR_W + 1)'(lim_sum >> BPW_W);
                            part_next      = bytes_clamped[BPW_W-1:0];
                            addr_next      = '0;
                            if (bytes_clamped == '0) begin
                                status_next = STATUS_NO_SPACE;
                                state_next  = ST_RESP;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MARK_WR: begin
                mem_we    = 1'b1;
                mem_waddr = chk_addr_reg;
                mem_wdata = rd_data_reg;
                mem_wdata[bit_reg] = (cmd_reg == CMD_MARK_USED);
                state_next = ST_RESP;
            end
            ST_SCAN: begin
                // one read issued per cycle, checked in the cycle after
                mem_raddr = addr_reg[ADDR_W-1:0];
                if (addr_reg != lim_words_reg) begin
                    chk_valid_next = 1'b1;
                    chk_addr_next  = addr_reg[ADDR_W-1:0];
                    addr_next      = addr_reg + (ADDR_W + 1)'(1);
                end
                if (chk_valid_reg) begin
                    if (free_bits != '0) begin
                        mem_we         = 1'b1;
                        mem_waddr      = chk_addr_reg;
                        mem_wdata      = rd_data_reg | low_free;
                        found_next     = FOUND_W'({chk_addr_reg, enc});
                        chk_valid_next = 1'b0;
                        chk_addr_next  = chk_addr_reg;
                        state_next     = ST_RESP;
                    end else if (last_word) begin
                        status_next    = STATUS_NO_SPACE;
                        chk_valid_next = 1'b0;
                        state_next     = ST_RESP;
                    end
                end
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({found_reg, status_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### tb/sv/tb_bitmap_block_allocator.sv
`timescale 1ns / 1ps
// testbench for bitmap_block_allocator: directed and random command streams, random stalls
// on both channels, every result checked against a bitmap model kept in the bench
// depends on bba_pkg and bitmap_block_allocator
module tb_bitmap_block_allocator;
    import bba_pkg::*;

    localparam int TIMEOUT_CYCLES  = 3_000_000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = MAP_WORDS + 64;

    typedef struct {
        status_t               status;
        logic [FOUND_W-1:0]    found_index;
    } alloc_reply_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = REG_BLOCK_COUNT;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    bit [WORD_BITS-1:0]     usage_words [MAP_WORDS];
    logic [COUNT_W-1:0]     block_count_q = BLOCK_COUNT_RESET;
    logic [MAPB_W-1:0]      map_bytes_q   = MAP_BYTES_RESET;
    alloc_reply_t           pending_replies [$];
    alloc_reply_t           want;
    int                     fail_count  = 0;
    int                     cycle_count = 0;
    bit                     tx_idle_en  = 1'b1;
    bit                     rx_stall_en = 1'b1;
    bit                     hold_start  = 1'b0;
    int                     hold_left   = 0;

    bitmap_block_allocator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, plus a long counted hold-off on request
    always @(posedge aclk) begin
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_OFF_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(rx_stall_en && $urandom_range(0, 99) < 20);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $error("result with nothing expected, m_tdata %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_tdata[STATUS_W-1:0] !== want.status) begin
                    $error("status expected %0d actual %0d", want.status,
                           m_tdata[STATUS_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[STATUS_W +: FOUND_W] !== want.found_index) begin
                    $error("found_index expected %0d actual %0d", want.found_index,
                           m_tdata[STATUS_W +: FOUND_W]);
                    fail_count++;
                end
            end
        end
    end

    function automatic alloc_reply_t apply_command(cmd_t cmd, logic [INDEX_W-1:0] idx);
        alloc_reply_t r;
        int           bytes;
        int           limit;
        r.status      = STATUS_OK;
        r.found_index = '0;
        case (cmd)
            CMD_CLEAR_ALL: begin
                foreach (usage_words[w]) usage_words[w] = '0;
            end
            CMD_MARK_USED, CMD_MARK_FREE: begin
                if (idx >= block_count_q || idx >= INDEX_W'(MAP_BITS)) begin
                    r.status = STATUS_BAD_INDEX;
                end else begin
                    usage_words[idx / WORD_BITS][idx % WORD_BITS] = (cmd == CMD_MARK_USED);
                end
            end
            default: begin
                bytes = map_bytes_q;
                if (bytes > MAP_BYTES) bytes = MAP_BYTES;
                limit    = bytes * BITS_PER_BYTE;
                r.status = STATUS_NO_SPACE;
                // first fit: lowest clear bit below the scan limit
                for (int b = 0; b < limit && r.status == STATUS_NO_SPACE; b++) begin
                    if (!usage_words[b / WORD_BITS][b % WORD_BITS]) begin
                        usage_words[b / WORD_BITS][b % WORD_BITS] = 1'b1;
                        r.status      = STATUS_OK;
                        r.found_index = FOUND_W'(b);
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_command(cmd_t cmd, logic [INDEX_W-1:0] idx);
        if (tx_idle_en && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({idx, cmd});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_replies.push_back(apply_command(cmd, idx));
    endtask

    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(int unsigned blocks, int unsigned bytes);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_BLOCK_COUNT;
        cfg_wdata <= CFG_DATA_W'(blocks);
        @(posedge aclk);
        cfg_addr  <= REG_MAP_BYTES;
        cfg_wdata <= CFG_DATA_W'(bytes);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        block_count_q = COUNT_W'(blocks);
        map_bytes_q   = MAPB_W'(bytes);
    endtask

    task automatic send_random_item(int unsigned span);
        cmd_t                 cmd;
        logic [INDEX_W-1:0]   idx;
        int unsigned          pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) cmd = CMD_CLEAR_ALL;
        else if (pick < 45) cmd = CMD_ALLOCATE;
        else if (pick < 68) cmd = CMD_MARK_USED;
        else cmd = CMD_MARK_FREE;
        pick = $urandom_range(0, 99);
        if (pick < 65) idx = $urandom_range(0, span);
        else if (pick < 80) idx = INDEX_W'(block_count_q) + $urandom_range(0, 2) - 1;
        else if (pick < 90) idx = INDEX_W'(MAP_BITS) - 2 + $urandom_range(0, 3);
        else idx = $urandom;
        send_command(cmd, idx);
    endtask

    task automatic test_default_config();
        send_command(CMD_ALLOCATE, '0);
        send_command(CMD_ALLOCATE, '1);
        send_command(CMD_MARK_USED, 32'd2);
        send_command(CMD_ALLOCATE, '0);
        send_command(CMD_MARK_FREE, 32'd0);
        send_command(CMD_ALLOCATE, '0);
        send_command(CMD_MARK_USED, 32'd65535);
        send_command(CMD_MARK_USED, 32'd65536);
        send_command(CMD_MARK_FREE, 32'hFFFF_FFFF);
        send_command(CMD_CLEAR_ALL, 32'h5555_AAAA);
        send_command(CMD_ALLOCATE, '0);
    endtask

    task automatic test_tiny_map();
        wait_for_replies();
        set_config(0, 1);
        repeat (8) send_command(CMD_ALLOCATE, '0);
        send_command(CMD_MARK_USED, 32'd0);
        send_command(CMD_MARK_FREE, 32'd3);
        wait_for_replies();
        set_config(5, 1);
        send_command(CMD_MARK_FREE, 32'd3);
        send_command(CMD_MARK_USED, 32'd5);
        send_command(CMD_ALLOCATE, '0);
        send_command(CMD_ALLOCATE, '0);
        wait_for_replies();
        set_config(COUNT_W'(65536), 0);
        send_command(CMD_ALLOCATE, '0);
    endtask

    task automatic test_output_hold_off();
        wait_for_replies();
        set_config(64, 8);
        tx_idle_en = 1'b0;
        hold_start = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_command((i % 3 == 2) ? CMD_MARK_FREE : CMD_ALLOCATE, $urandom_range(0, 70));
        end
        tx_idle_en = 1'b1;
        wait_for_replies();
    endtask

    task automatic test_random_settings();
        int unsigned blocks;
        int unsigned bytes;
        int unsigned span;
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin blocks = 65536; bytes = 8192;  end
                1: begin blocks = 0;     bytes = 2;     end
                2: begin blocks = 1;     bytes = 0;     end
                3: begin blocks = 37;    bytes = 5;     end
                4: begin blocks = 65535; bytes = 16383; end
                5: begin blocks = 300;   bytes = 40;    end
                default: begin blocks = 65536; bytes = 3; end
            endcase
            wait_for_replies();
            set_config(blocks, bytes);
            tx_idle_en  = (p != 3);
            rx_stall_en = (p != 3);
            span = ((bytes > MAP_BYTES) ? MAP_BYTES : bytes) * BITS_PER_BYTE + 8;
            if (span > 320) span = 320;
            repeat (36) send_random_item(span);
        end
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_config();
        test_tiny_map();
        test_output_hold_off();
        test_random_settings();
        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_replies.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
